/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CKC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ckc assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define CKC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ckc assertion failed");

`endif

/* hw/rtl/ckc_pkg.sv */
package ckc_pkg;

	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int ROW_W     = 13;
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = 2;

	localparam logic [1:0]  PC_READY  = 2'd3;
	localparam logic [15:0] KEY_RESET = 16'hF81F;

	localparam logic [1:0] FUNC_MARK     = 2'd0;
	localparam logic [1:0] FUNC_MARK_ALL = 2'd1;
	localparam logic [1:0] FUNC_PIXEL    = 2'd2;
	localparam logic [1:0] FUNC_END      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY         = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LAYERS      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BG_SIZE     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_WEATHER_WIN = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIN    = CFG_IDX_W'(4);

	typedef struct packed {
		logic [1:0]         func;
		logic [8:0]         pix_x;
		logic [7:0]         pix_y;
		logic signed [15:0] row_start;
		logic signed [15:0] row_count;
		logic [15:0]        old_pixel;
		logic [15:0]        bg_pixel;
		logic [15:0]        stream_pixel;
		logic [15:0]        weather_pixel;
		logic [15:0]        char_pixel;
	} ckc_in_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic        write_enable;
		logic [8:0]  dirty_rows;
	} ckc_out_t;

	typedef enum logic [1:0] {
		OP_MARK  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_END   = 2'd2
	} ckc_op_t;

	typedef struct packed {
		ckc_op_t          op;
		logic             hit;
		logic [15:0]      new_pix;
		logic [15:0]      old_pix;
		logic [ROW_W-1:0] row_lo;
		logic [ROW_W-1:0] row_hi;
	} ckc_entry_t;

	typedef struct packed {
		logic pop;
		logic fire_out;
		logic end_fire;
		logic dirty_any;
	} ckc_back_stat_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

/* hw/rtl/ckc_front.sv */
module ckc_front #(
	parameter int FRAME_W = 512,
	parameter int FRAME_H = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ckc_pkg::CFG_W-1:0]      cfg_data,
	input  ckc_pkg::ckc_in_t               item,
	output ckc_pkg::ckc_entry_t            entry
);
	import ckc_pkg::*;

	localparam logic signed [17:0] FH_S = 18'(FRAME_H);

	logic [15:0] key_q;
	logic [3:0]  en_q;
	logic [31:0] bg_q;
	logic [63:0] wwin_q;
	logic [63:0] cwin_q;

	logic signed [17:0] x_s, y_s;
	logic signed [17:0] ys, cnt, ye, lo, hi;
	logic               x_in_w, y_in_h, bg_on, bg_col, st_ok, w_hit, c_hit;
	logic [15:0]        cur;

	function automatic logic in_win(input logic [63:0] win, input logic signed [17:0] x,
			input logic signed [17:0] y);
		logic signed [17:0] wx, wy, xe, ye_w;
		wx   = 18'(signed'(win[15:0]));
		wy   = 18'(signed'(win[31:16]));
		xe   = wx + signed'({2'b00, win[47:32]});
		ye_w = wy + signed'({2'b00, win[63:48]});
		return (y >= wy) && (y < ye_w) && (x >= wx) && (x < xe);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= KEY_RESET;
			en_q   <= '0;
			bg_q   <= '0;
			wwin_q <= '0;
			cwin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY:         key_q  <= cfg_data[15:0];
				REG_LAYERS:      en_q   <= cfg_data[3:0];
				REG_BG_SIZE:     bg_q   <= cfg_data[31:0];
				REG_WEATHER_WIN: wwin_q <= cfg_data;
				REG_CHAR_WIN:    cwin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		x_s    = signed'({9'd0, item.pix_x});
		y_s    = signed'({10'd0, item.pix_y});
		x_in_w = {23'd0, item.pix_x} < 32'(FRAME_W);
		y_in_h = {24'd0, item.pix_y} < 32'(FRAME_H);
		bg_on  = en_q[0] && ({8'd0, item.pix_y} < bg_q[31:16]);
		bg_col = ({7'd0, item.pix_x} < bg_q[15:0]) && x_in_w;
		st_ok  = en_q[1] && (item.stream_pixel != key_q);
		w_hit  = en_q[2] && in_win(wwin_q, x_s, y_s) && x_in_w && (item.weather_pixel != key_q);
		c_hit  = en_q[3] && in_win(cwin_q, x_s, y_s) && x_in_w && (item.char_pixel != key_q);

		// base layer
		if (bg_on) begin
			if (bg_col) begin
				cur = swap16(st_ok ? item.stream_pixel : item.bg_pixel);
			end else begin
				cur = item.old_pixel;
			end
		end else begin
			cur = st_ok ? swap16(item.stream_pixel) : 16'd0;
		end
		if (w_hit) begin
			cur = swap16(item.weather_pixel);
		end
		if (c_hit) begin
			cur = swap16(item.char_pixel);
		end

		// clipped mark range
		ys  = 18'(signed'(item.row_start));
		cnt = 18'(signed'(item.row_count));
		ye  = ys + cnt;
		if (ys < 18'sd0) begin
			lo = 18'sd0;
		end else if (ys > FH_S) begin
			lo = FH_S;
		end else begin
			lo = ys;
		end
		if (cnt <= 18'sd0 || ye < 18'sd0) begin
			hi = 18'sd0;
		end else if (ye > FH_S) begin
			hi = FH_S;
		end else begin
			hi = ye;
		end

		entry.hit     = 1'b0;
		entry.new_pix = cur;
		entry.old_pix = item.old_pixel;
		entry.row_lo  = ROW_W'(lo);
		entry.row_hi  = ROW_W'(hi);
		case (item.func)
			FUNC_MARK: begin
				entry.op = OP_MARK;
			end
			FUNC_MARK_ALL: begin
				entry.op     = OP_MARK;
				entry.row_lo = '0;
				entry.row_hi = ROW_W'(FRAME_H);
			end
			FUNC_PIXEL: begin
				entry.op     = OP_PIXEL;
				entry.hit    = x_in_w && y_in_h;
				entry.row_lo = ROW_W'(item.pix_y);
			end
			FUNC_END: begin
				entry.op = OP_END;
			end
			default: begin
				entry.op = OP_END;
			end
		endcase
	end

endmodule

/* hw/rtl/ckc_queue.sv */
module ckc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ckc_pkg::ckc_entry_t  wr_entry,
	output logic                 full,
	output logic                 valid,
	output ckc_pkg::ckc_entry_t  head,
	input  logic                 pop
);
	import ckc_pkg::*;

	ckc_entry_t      mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push, do_pop;

	assign full    = cnt_q == (Q_AW + 1)'(Q_DEPTH);
	assign valid   = cnt_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/ckc_back.sv */
module ckc_back #(
	parameter int FRAME_H = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  ckc_pkg::ckc_entry_t      head,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output ckc_pkg::ckc_out_t        out_item,
	output ckc_pkg::ckc_back_stat_t  stat
);
	import ckc_pkg::*;

	localparam int RW  = $clog2(FRAME_H);
	localparam int HW  = $clog2(FRAME_H + 1);
	localparam int NG  = (FRAME_H + 7) / 8;
	localparam int NG2 = (NG + 7) / 8;

	logic [FRAME_H-1:0] dirty_q;
	logic [FRAME_H-1:0] mark_mask;
	logic [3:0]         grp_d  [NG];
	logic [3:0]         grp_s1 [NG];
	logic [6:0]         sum_d  [NG2];
	logic [6:0]         sum_s2 [NG2];
	logic [HW-1:0]      total_d, total_s3;
	logic [1:0]         wait_q;
	logic               out_valid_q;
	ckc_out_t           out_q;

	logic          out_free, end_ready, row_dirty, fire_out;
	logic [RW-1:0] row_idx;
	logic [8:0]    dcount;

	assign out_free  = !out_valid_q || !out_stall;
	assign end_ready = wait_q == PC_READY;
	assign row_idx   = head.row_lo[RW-1:0];
	assign row_dirty = head.hit && dirty_q[row_idx];
	assign dcount    = (32'(total_s3) > 32'd511) ? 9'd511 : 9'(total_s3);

	always_comb begin
		case (head.op)
			OP_MARK:  pop = q_valid;
			OP_PIXEL: pop = q_valid && out_free;
			OP_END:   pop = q_valid && out_free && end_ready;
			default:  pop = q_valid;
		endcase
		fire_out = pop && (head.op == OP_PIXEL || head.op == OP_END);
	end

	always_comb begin
		for (int r = 0; r < FRAME_H; r++) begin
			mark_mask[r] = (ROW_W'(r) >= head.row_lo) && (ROW_W'(r) < head.row_hi);
		end
	end

	// population count tree of the dirty bits
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (8 * g + b < FRAME_H) begin
					grp_d[g] = grp_d[g] + 4'(dirty_q[8 * g + b]);
				end
			end
		end
		for (int k = 0; k < NG2; k++) begin
			sum_d[k] = '0;
			for (int j = 0; j < 8; j++) begin
				if (8 * k + j < NG) begin
					sum_d[k] = sum_d[k] + 7'(grp_s1[8 * k + j]);
				end
			end
		end
		total_d = '0;
		for (int k = 0; k < NG2; k++) begin
			total_d = total_d + HW'(sum_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		grp_s1   <= grp_d;
		sum_s2   <= sum_d;
		total_s3 <= total_d;
		if (fire_out) begin
			if (head.op == OP_PIXEL) begin
				out_q.pixel_out    <= row_dirty ? head.new_pix : head.old_pix;
				out_q.write_enable <= row_dirty;
				out_q.dirty_rows   <= '0;
			end else begin
				out_q.pixel_out    <= '0;
				out_q.write_enable <= 1'b0;
				out_q.dirty_rows   <= dcount;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q     <= '1;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.op == OP_MARK) begin
				dirty_q <= dirty_q | mark_mask;
			end else if (pop && head.op == OP_END) begin
				dirty_q <= '0;
			end
			// count settles once the dirty bits stay still through the tree
			if (pop) begin
				wait_q <= '0;
			end else if (q_valid && head.op == OP_END && !end_ready) begin
				wait_q <= wait_q + 1'b1;
			end
			if (fire_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign stat.pop       = pop;
	assign stat.fire_out  = fire_out;
	assign stat.end_fire  = pop && head.op == OP_END;
	assign stat.dirty_any = |dirty_q;

endmodule

/* hw/rtl/color_key_layer_compositor.sv */
// with the queue empty and the output free, a pixel beat is written into the queue, then
//   popped and its result registered; an end-frame beat also waits for the dirty-row count
// throughput: one beat per cycle while the output does not stall; an end-frame beat holds
//   the back end while the registered population count of the dirty bits settles
// a 4-entry queue parts the classifying front end from the dirty-row back end
// reset: all rows dirty, key color 0xF81F, other registers zero, no clearing pass
`include "assert_macros.svh"

module color_key_layer_compositor #(
	parameter int FRAME_W = 512,
	parameter int FRAME_H = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ckc_pkg::ckc_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ckc_pkg::ckc_out_t              out_item,
	input  logic                           cfg_we,
	input  logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ckc_pkg::CFG_W-1:0]      cfg_data
);
	import ckc_pkg::*;

	ckc_entry_t     wr_entry;
	ckc_entry_t     head;
	logic           q_full, q_valid, pop;
	ckc_back_stat_t stat;

	ckc_front #(
		.FRAME_W (FRAME_W),
		.FRAME_H (FRAME_H)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (in_item),
		.entry     (wr_entry)
	);

	ckc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.wr_entry (wr_entry),
		.full     (q_full),
		.valid    (q_valid),
		.head     (head),
		.pop      (pop)
	);

	ckc_back #(
		.FRAME_H (FRAME_H)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.stat      (stat)
	);

	assign in_stall = q_full;

	`CKC_ASSERT_IMP(a_pop_nonempty, stat.pop, q_valid)
	`CKC_ASSERT_NXT(a_end_clears, stat.end_fire, !stat.dirty_any)
	`CKC_ASSERT_NXT(a_result_shown, stat.fire_out, out_valid)

endmodule

/* bench/tb_color_key_layer_compositor.sv */
module tb_color_key_layer_compositor;
	timeunit 1ns;
	timeprecision 1ps;

	import ckc_pkg::*;

	localparam int REG_COUNT = 5;

	localparam int LAYER_BG      = 0;
	localparam int LAYER_STREAM  = 1;
	localparam int LAYER_WEATHER = 2;
	localparam int LAYER_CHAR    = 3;

	localparam int ROWS           = 256;
	localparam int COLS           = 512;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int RANDOM_PHASES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 12;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	ckc_in_t          in_item = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	ckc_out_t         out_item;
	logic             cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [15:0]      key_rgb;
	logic [3:0]       layers;
	logic [31:0]      bg_dims;
	logic [63:0]      weather_win;
	logic [63:0]      char_win;
	bit [ROWS-1:0]    row_dirty;

	ckc_out_t         pending_outputs[$];

	int errors = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int hold_req = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	color_key_layer_compositor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [15:0] display_order(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic bit overlay_hits(input logic [63:0] win, input int x, input int y);
		int wx, wy, ww, wh;
		wx = $signed(win[15:0]);
		wy = $signed(win[31:16]);
		ww = win[47:32];
		wh = win[63:48];
		if (y < wy || y >= wy + wh)
			return 1'b0;
		return x >= wx && x < wx + ww && x < COLS;
	endfunction

	task automatic composite_and_mark(input ckc_in_t it);
		ckc_out_t res;
		int x, y, bw, bh, cw, s, c, y0, y1;
		logic [15:0] cur;
		bit stream_ok;
		res = '0;
		case (it.func)
			FUNC_MARK: begin
				s = $signed(it.row_start);
				c = $signed(it.row_count);
				if (c > 0) begin
					y0 = s < 0 ? 0 : s;
					y1 = s + c;
					if (y1 > ROWS)
						y1 = ROWS;
					for (int row = y0; row < y1; row++)
						row_dirty[row] = 1'b1;
				end
			end
			FUNC_MARK_ALL: begin
				row_dirty = '1;
			end
			FUNC_END: begin
				res.dirty_rows = 9'($countones(row_dirty));
				row_dirty = '0;
				pending_outputs.push_back(res);
			end
			FUNC_PIXEL: begin
				x = it.pix_x;
				y = it.pix_y;
				if (x >= COLS || y >= ROWS || !row_dirty[y]) begin
					res.pixel_out = it.old_pixel;
				end else begin
					stream_ok = layers[LAYER_STREAM] && it.stream_pixel != key_rgb;
					bw = bg_dims[15:0];
					bh = bg_dims[31:16];
					if (layers[LAYER_BG] && y < bh) begin
						cw = bw < COLS ? bw : COLS;
						cur = it.old_pixel;
						if (x < cw)
							cur = display_order(stream_ok ? it.stream_pixel : it.bg_pixel);
					end else begin
						cur = stream_ok ? display_order(it.stream_pixel) : 16'h0000;
					end
					if (layers[LAYER_WEATHER] && overlay_hits(weather_win, x, y) &&
							it.weather_pixel != key_rgb)
						cur = display_order(it.weather_pixel);
					if (layers[LAYER_CHAR] && overlay_hits(char_win, x, y) &&
							it.char_pixel != key_rgb)
						cur = display_order(it.char_pixel);
					res.pixel_out = cur;
					res.write_enable = 1'b1;
				end
				pending_outputs.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : check_results
		ckc_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_outputs.size() == 0) begin
				report("result beat with nothing pending", out_item.pixel_out, 16'h0000);
			end else begin
				want = pending_outputs.pop_front();
				if (out_item.pixel_out !== want.pixel_out)
					report("pixel_out", out_item.pixel_out, want.pixel_out);
				if (out_item.write_enable !== want.write_enable)
					report("write_enable", 16'(out_item.write_enable), 16'(want.write_enable));
				if (out_item.dirty_rows !== want.dirty_rows)
					report("dirty_rows", 16'(out_item.dirty_rows), 16'(want.dirty_rows));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 6);
				default: out_stall <= mode_left[2];
			endcase
		end
	end

	task automatic send_beat(input ckc_in_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		composite_and_mark(it);
		beats_sent++;
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_KEY:         key_rgb = d[15:0];
			REG_LAYERS:      layers = d[3:0];
			REG_BG_SIZE:     bg_dims = d[31:0];
			REG_WEATHER_WIN: weather_win = d;
			REG_CHAR_WIN:    char_win = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic ckc_in_t pixel_beat(input logic [8:0] x, input logic [7:0] y,
			input logic [15:0] oldp, input logic [15:0] bgp, input logic [15:0] stp,
			input logic [15:0] wp, input logic [15:0] cp);
		ckc_in_t it;
		it = '0;
		it.func = FUNC_PIXEL;
		it.pix_x = x;
		it.pix_y = y;
		it.old_pixel = oldp;
		it.bg_pixel = bgp;
		it.stream_pixel = stp;
		it.weather_pixel = wp;
		it.char_pixel = cp;
		return it;
	endfunction

	function automatic ckc_in_t row_beat(input logic [1:0] f, input logic signed [15:0] s,
			input logic signed [15:0] c);
		ckc_in_t it;
		it = '0;
		it.func = f;
		it.row_start = s;
		it.row_count = c;
		return it;
	endfunction

	function automatic logic [15:0] key_or_any();
		return ($urandom_range(0, 3) == 0) ? key_rgb : 16'($urandom);
	endfunction

	function automatic ckc_in_t random_beat();
		ckc_in_t it;
		int pick, s, c;
		pick = $urandom_range(0, 99);
		it.func = pick < 70 ? FUNC_PIXEL : pick < 82 ? FUNC_MARK
			: pick < 86 ? FUNC_MARK_ALL : FUNC_END;
		it.pix_x = 9'($urandom);
		it.pix_y = 8'($urandom);
		it.old_pixel = 16'($urandom);
		it.bg_pixel = key_or_any();
		it.stream_pixel = key_or_any();
		it.weather_pixel = key_or_any();
		it.char_pixel = key_or_any();
		s = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300) - 20;
		c = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 70) - 5;
		it.row_start = s[15:0];
		it.row_count = c[15:0];
		return it;
	endfunction

	function automatic logic [63:0] random_window();
		int x, y, w, h;
		if ($urandom_range(0, 7) == 0)
			return {$urandom, $urandom};
		x = $urandom_range(0, 600) - 60;
		y = $urandom_range(0, 320) - 40;
		w = $urandom_range(0, 300);
		h = $urandom_range(0, 120);
		return {h[15:0], w[15:0], y[15:0], x[15:0]};
	endfunction

	task automatic random_settings(input int phase);
		int bw, bh;
		settings_used++;
		if (phase == 0) begin
			set_reg(REG_KEY, '0);
			set_reg(REG_LAYERS, 64'hF);
			set_reg(REG_BG_SIZE, 64'hFFFF_FFFF);
			set_reg(REG_WEATHER_WIN, '1);
			set_reg(REG_CHAR_WIN, '1);
		end else if (phase == 1) begin
			set_reg(REG_KEY, 64'hFFFF);
			set_reg(REG_LAYERS, '0);
			set_reg(REG_BG_SIZE, '0);
			set_reg(REG_WEATHER_WIN, '0);
			set_reg(REG_CHAR_WIN, '0);
		end else begin
			bw = $urandom_range(0, 600);
			bh = $urandom_range(0, 300);
			set_reg(REG_KEY, 64'($urandom));
			set_reg(REG_LAYERS, 64'($urandom_range(0, 15)));
			set_reg(REG_BG_SIZE, ($urandom_range(0, 7) == 0) ? 64'($urandom)
				: {32'h0, bh[15:0], bw[15:0]});
			set_reg(REG_WEATHER_WIN, random_window());
			set_reg(REG_CHAR_WIN, random_window());
		end
	endtask

	task automatic test_reset_defaults();
		for (int idx = REG_COUNT; idx < (1 << CFG_IDX_W); idx++)
			set_reg(idx[CFG_IDX_W-1:0], '1);
		// all layers off after reset: dirty row goes black
		send_beat(pixel_beat(9'd0, 8'd0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0FF0));
		send_beat(row_beat(FUNC_END, 16'sd0, 16'sd0));
		// clean row keeps old pixel
		send_beat(pixel_beat(9'd511, 8'd255, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'h0000));
		wait_idle();
	endtask

	task automatic test_row_marking();
		send_beat(row_beat(FUNC_MARK, -16'sd5, 16'sd10));
		send_beat(row_beat(FUNC_MARK, 16'sd300, 16'sd5));
		send_beat(row_beat(FUNC_MARK, 16'sd250, 16'sd100));
		send_beat(row_beat(FUNC_MARK, 16'sd10, 16'sd0));
		send_beat(row_beat(FUNC_MARK, 16'sd20, -16'sd3));
		send_beat(row_beat(FUNC_MARK, -16'sd32768, 16'sd32767));
		send_beat(row_beat(FUNC_MARK, 16'sd32767, 16'sd32767));
		send_beat(row_beat(FUNC_END, 16'sd0, 16'sd0));
		send_beat(row_beat(FUNC_MARK_ALL, 16'sd0, 16'sd0));
		send_beat(row_beat(FUNC_END, 16'sd0, 16'sd0));
		send_beat(row_beat(FUNC_END, 16'sd0, 16'sd0));
		wait_idle();
	endtask

	task automatic test_base_layers();
		settings_used++;
		set_reg(REG_LAYERS, 64'h3);
		set_reg(REG_BG_SIZE, {32'h0, 16'd50, 16'd100});
		send_beat(row_beat(FUNC_MARK_ALL, 16'sd0, 16'sd0));
		send_beat(pixel_beat(9'd10, 8'd5, 16'hAAAA, 16'h1357, 16'h1234, 16'h0, 16'h0));
		send_beat(pixel_beat(9'd10, 8'd5, 16'hAAAA, 16'h1357, KEY_RESET, 16'h0, 16'h0));
		// past the background width: old pixel rewritten as is
		send_beat(pixel_beat(9'd200, 8'd5, 16'hBEEF, 16'h1357, 16'h1234, 16'h0, 16'h0));
		send_beat(pixel_beat(9'd10, 8'd100, 16'hBEEF, 16'h1357, KEY_RESET, 16'h0, 16'h0));
		wait_idle();
	endtask

	task automatic test_overlays();
		settings_used++;
		set_reg(REG_LAYERS, 64'hF);
		set_reg(REG_BG_SIZE, '0);
		set_reg(REG_WEATHER_WIN, {16'd10, 16'd10, 16'hFFFE, 16'hFFFC});
		set_reg(REG_CHAR_WIN, {16'd1, 16'd507, 16'd3, 16'd5});
		send_beat(pixel_beat(9'd0, 8'd0, 16'h0, 16'h0, 16'h2222, 16'h3344, 16'h5566));
		send_beat(pixel_beat(9'd5, 8'd3, 16'h0, 16'h0, 16'h2222, 16'h3344, 16'h5566));
		send_beat(pixel_beat(9'd5, 8'd3, 16'h0, 16'h0, 16'h2222, 16'h3344, KEY_RESET));
		send_beat(pixel_beat(9'd511, 8'd3, 16'h0, 16'h0, KEY_RESET, 16'h3344, 16'h5566));
		send_beat(pixel_beat(9'd6, 8'd8, 16'h0, 16'h0, KEY_RESET, KEY_RESET, 16'h5566));
		wait_idle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_settings(phase);
			if ($urandom_range(0, 1) == 0)
				send_beat(row_beat(FUNC_MARK_ALL, 16'sd0, 16'sd0));
			for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
				send_beat(random_beat());
				pace_sender();
			end
			wait_idle();
		end
	endtask

	task automatic test_output_holdoff();
		hold_req = HOLD_CYCLES;
		repeat (40) send_beat(random_beat());
		wait_idle();
	endtask

	initial begin
		key_rgb = KEY_RESET;
		layers = '0;
		bg_dims = '0;
		weather_win = '0;
		char_win = '0;
		row_dirty = '1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_row_marking();
		test_base_layers();
		test_overlays();
		test_random_traffic();
		test_output_holdoff();

		$display("%0d beats sent, %0d result beats checked, %0d register settings",
			beats_sent, results_seen, settings_used);
		$display("covered row marking and clipping, frame-end counts, base and overlay keying,");
		$display("idle gaps, receiver stalls and a %0d-cycle output hold-off", HOLD_CYCLES);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
